@@ hw/rtl/alfp_pkg.sv @@
// Shared types, constants and helpers for the array linked list free pool.
// No dependencies; every module of the block imports this package.
`default_nettype none

package alfp_pkg;

    // Pool geometry
    localparam int POOL_NODES   = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int NODE_CNT     = POOL_NODES + 1;          // entry 0 is nil
    localparam int MAX_OUT      = 16;
    localparam int TRV_LIMIT    = (MAX_OUT < POOL_NODES) ? MAX_OUT : POOL_NODES;
    localparam int CNT_W        = $clog2(TRV_LIMIT + 1);

    // Field widths fixed by the stream format
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 8 * ((IDX_W + WORD_W + 7) / 8);
    localparam int OUT_FLD_W  = IDX_W + WORD_W + IDX_W + 2;
    localparam int OUT_DATA_W = 8 * ((OUT_FLD_W + 7) / 8);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_INS_RD_FREE,
        ST_INS_RD_POS,
        ST_INS_WR_POS,
        ST_DEL_HEAD_RD,
        ST_DEL_POS_RD,
        ST_DEL_SUCC_RD,
        ST_DEL_REL,
        ST_TRV_RD,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [IDX_W-1:0]        position;
        logic [PAYLOAD_BITS-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    node_index;
        logic [WORD_W-1:0]   node_payload;
        logic [IDX_W-1:0]    node_next;
        logic                list_empty;
        logic                pool_full;
        logic                last;
    } result_t;

    typedef struct packed {
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
        logic                    link_wr_en;
        logic [IDX_W-1:0]        link_wr_addr;
        logic [IDX_W-1:0]        link_wr_data;
        logic                    pay_wr_en;
        logic [IDX_W-1:0]        pay_wr_addr;
        logic [PAYLOAD_BITS-1:0] pay_wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        link;
        logic [PAYLOAD_BITS-1:0] payload;
    } mem_rsp_t;

    // Link value of an entry that was never written: a chain 1 -> 2 -> ... -> nil
    function automatic logic [IDX_W-1:0] link_init(input logic [IDX_W-1:0] addr);
        logic [IDX_W-1:0] res;
        res = '0;
        if ((addr != '0) && (addr < IDX_W'(POOL_NODES)))
        begin
            res = addr + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/alfp_node_mem.sv @@
// Node storage: link memory with per-entry written bits and payload memory.
// One registered read port over both, one write port each. Uses alfp_pkg.
`default_nettype none

module alfp_node_mem
    import alfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output mem_rsp_t      rsp
);

    logic [IDX_W-1:0]        link_mem [NODE_CNT];
    logic [PAYLOAD_BITS-1:0] pay_mem  [NODE_CNT];
    logic [NODE_CNT-1:0]     link_wr_reg;
    logic [IDX_W-1:0]        link_q_reg;
    logic [PAYLOAD_BITS-1:0] pay_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_wr_reg <= '0;
        end
        else if (req.link_wr_en)
        begin
            link_wr_reg[req.link_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.link_wr_en)
        begin
            link_mem[req.link_wr_addr] <= req.link_wr_data;
        end
        if (req.pay_wr_en)
        begin
            pay_mem[req.pay_wr_addr] <= req.pay_wr_data;
        end
        // unwritten link entries read as their reset chain value
        if (req.rd_en)
        begin
            link_q_reg <= link_wr_reg[req.rd_addr] ? link_mem[req.rd_addr]
                                                   : link_init(req.rd_addr);
            pay_q_reg  <= pay_mem[req.rd_addr];
        end
    end

    assign rsp.link    = link_q_reg;
    assign rsp.payload = pay_q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/alfp_seq.sv @@
// Operation sequencer: heads, in-use bits and the step order of each command.
// Drives the node memory port and hands results out. Uses alfp_pkg.
`default_nettype none

module alfp_seq
    import alfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cmd_t     cmd,
    input  wire logic     out_free,
    output logic          emit,
    output result_t       res,
    output mem_req_t      mem_req,
    input  wire mem_rsp_t mem_rsp
);

    seq_state_t              state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0]        node_reg, node_next;
    logic [IDX_W-1:0]        list_head_reg, list_head_next;
    logic [IDX_W-1:0]        free_head_reg, free_head_next;
    logic [NODE_CNT-1:0]     in_use_reg, in_use_next;
    logic [STATUS_W-1:0]     rstat_reg, rstat_next;
    logic [IDX_W-1:0]        rnode_reg, rnode_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic pos_valid;
    logic trv_fin;

    assign pos_valid = (pos_reg != '0) && (pos_reg <= IDX_W'(POOL_NODES))
                       && in_use_reg[pos_reg];
    assign trv_fin   = (mem_rsp.link == '0) || (cnt_reg == CNT_W'(TRV_LIMIT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            list_head_reg <= '0;
            free_head_reg <= IDX_W'(1);
            in_use_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            in_use_reg    <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        pos_reg   <= pos_next;
        pay_reg   <= pay_next;
        node_reg  <= node_next;
        rstat_reg <= rstat_next;
        rnode_reg <= rnode_next;
        cnt_reg   <= cnt_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if ((free_head_reg == '0) || ((pos_reg != '0) && !pos_valid))
                            state_next = ST_EMIT;
                        else
                            state_next = ST_INS_RD_FREE;
                    end
                    MODE_DELETE:
                    begin
                        if (list_head_reg == '0)
                            state_next = ST_EMIT;
                        else if (pos_reg == '0)
                            state_next = ST_DEL_HEAD_RD;
                        else if (!pos_valid)
                            state_next = ST_EMIT;
                        else
                            state_next = ST_DEL_POS_RD;
                    end
                    MODE_TRAVERSE:
                    begin
                        if (list_head_reg == '0)
                            state_next = ST_EMIT;
                        else
                            state_next = ST_TRV_RD;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_INS_RD_FREE:
            begin
                state_next = (pos_reg == '0) ? ST_EMIT : ST_INS_RD_POS;
            end
            ST_INS_RD_POS:  state_next = ST_INS_WR_POS;
            ST_INS_WR_POS:  state_next = ST_EMIT;
            ST_DEL_HEAD_RD: state_next = ST_EMIT;
            ST_DEL_POS_RD:
            begin
                state_next = (mem_rsp.link == '0) ? ST_EMIT : ST_DEL_SUCC_RD;
            end
            ST_DEL_SUCC_RD: state_next = ST_DEL_REL;
            ST_DEL_REL:     state_next = ST_EMIT;
            ST_TRV_RD:
            begin
                if (out_free && trv_fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath, memory port and result
    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        pay_next       = pay_reg;
        node_next      = node_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        in_use_next    = in_use_reg;
        rstat_next     = rstat_reg;
        rnode_next     = rnode_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        emit           = 1'b0;
        res            = '0;
        mem_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next = cmd.mode;
                    pos_next  = cmd.position;
                    pay_next  = cmd.payload;
                end
            end
            ST_CHECK:
            begin
                rstat_next = STS_OK;
                rnode_next = '0;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (free_head_reg == '0)
                        begin
                            rstat_next = STS_FULL;
                        end
                        else if ((pos_reg != '0) && !pos_valid)
                        begin
                            rstat_next = STS_BADPOS;
                        end
                        else
                        begin
                            // pop the free head: fetch its link, store the payload
                            node_next                  = free_head_reg;
                            in_use_next[free_head_reg] = 1'b1;
                            mem_req.rd_en              = 1'b1;
                            mem_req.rd_addr            = free_head_reg;
                            mem_req.pay_wr_en          = 1'b1;
                            mem_req.pay_wr_addr        = free_head_reg;
                            mem_req.pay_wr_data        = pay_reg;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (list_head_reg == '0)
                        begin
                            rstat_next = STS_EMPTY;
                        end
                        else if (pos_reg == '0)
                        begin
                            node_next       = list_head_reg;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = list_head_reg;
                        end
                        else if (!pos_valid)
                        begin
                            rstat_next = STS_BADPOS;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = pos_reg;
                        end
                    end
                    MODE_TRAVERSE:
                    begin
                        if (list_head_reg == '0)
                        begin
                            rstat_next = STS_EMPTY;
                        end
                        else
                        begin
                            node_next       = list_head_reg;
                            cnt_next        = '0;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = list_head_reg;
                        end
                    end
                    default:
                    begin
                        rstat_next = STS_OK;
                    end
                endcase
            end
            ST_INS_RD_FREE:
            begin
                free_head_next = mem_rsp.link;
                rstat_next     = STS_OK;
                rnode_next     = node_reg;
                if (pos_reg == '0)
                begin
                    mem_req.link_wr_en   = 1'b1;
                    mem_req.link_wr_addr = node_reg;
                    mem_req.link_wr_data = list_head_reg;
                    list_head_next       = node_reg;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = pos_reg;
                end
            end
            ST_INS_RD_POS:
            begin
                mem_req.link_wr_en   = 1'b1;
                mem_req.link_wr_addr = node_reg;
                mem_req.link_wr_data = mem_rsp.link;
            end
            ST_INS_WR_POS:
            begin
                mem_req.link_wr_en   = 1'b1;
                mem_req.link_wr_addr = pos_reg;
                mem_req.link_wr_data = node_reg;
            end
            ST_DEL_HEAD_RD:
            begin
                list_head_next        = mem_rsp.link;
                mem_req.link_wr_en    = 1'b1;
                mem_req.link_wr_addr  = node_reg;
                mem_req.link_wr_data  = free_head_reg;
                free_head_next        = node_reg;
                in_use_next[node_reg] = 1'b0;
                rstat_next            = STS_OK;
                rnode_next            = node_reg;
            end
            ST_DEL_POS_RD:
            begin
                if (mem_rsp.link == '0)
                begin
                    rstat_next = STS_BADPOS;
                    rnode_next = '0;
                end
                else
                begin
                    node_next       = mem_rsp.link;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rsp.link;
                end
            end
            ST_DEL_SUCC_RD:
            begin
                // bypass the victim
                mem_req.link_wr_en   = 1'b1;
                mem_req.link_wr_addr = pos_reg;
                mem_req.link_wr_data = mem_rsp.link;
            end
            ST_DEL_REL:
            begin
                mem_req.link_wr_en    = 1'b1;
                mem_req.link_wr_addr  = node_reg;
                mem_req.link_wr_data  = free_head_reg;
                free_head_next        = node_reg;
                in_use_next[node_reg] = 1'b0;
                rstat_next            = STS_OK;
                rnode_next            = node_reg;
            end
            ST_TRV_RD:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    res.status       = STS_OK;
                    res.node_index   = node_reg;
                    res.node_payload = WORD_W'(mem_rsp.payload);
                    res.node_next    = mem_rsp.link;
                    res.list_empty   = (list_head_reg == '0);
                    res.pool_full    = (free_head_reg == '0);
                    res.last         = trv_fin;
                    if (!trv_fin)
                    begin
                        node_next       = mem_rsp.link;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = mem_rsp.link;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    res.status     = rstat_reg;
                    res.node_index = rnode_reg;
                    res.list_empty = (list_head_reg == '0);
                    res.pool_full  = (free_head_reg == '0);
                    res.last       = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result handed out with the output stage full");

    a_heads_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (list_head_reg != '0) |-> (list_head_reg != free_head_reg))
        else $error("list head and free head name the same node");

    a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (list_head_reg != '0) |-> in_use_reg[list_head_reg])
        else $error("list head node is not marked in use");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command taken while one is in flight");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/array_linked_list_free_pool.sv @@
// Top level of the array linked list free pool: stream ports and output register.
// Instantiates alfp_seq and alfp_node_mem; uses alfp_pkg.
//
//  Channel  | Direction | tdata (low bit up)                         | tuser  | tlast
//  ---------+-----------+--------------------------------------------+--------+-------
//  s_axis   | in        | position[4:0], payload[36:5], zero fill     | mode   | -
//  m_axis   | out       | node_index, node_payload, node_next,        | status | last
//           |           | list_empty, pool_full, zero fill            |        |
//
// Steps after the check: none for error answers and unused mode 3; a delete naming
// the tail node reads it; insert or delete at the head reads the free or list head;
// insert after a node also reads it and writes both links; delete after a node reads
// it and its successor, then bypasses and frees the victim; traverse reads each node.
// All link reads and writes go through the single node memory port; the
// sequencer steps one command at a time and drops s_axis_tready meanwhile.
// Reset sets both heads, clears in-use bits and link written bits; no clearing pass.
// A stalled m_axis holds the result beat and the sequencer waits on it.
`default_nettype none

module array_linked_list_free_pool
    import alfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // position, payload
    input  wire logic [MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // node_index, node_payload,
                                                       // node_next, list_empty, pool_full
    output logic [STATUS_W-1:0]        m_axis_tuser,   // status
    output logic                       m_axis_tlast    // last
);

    cmd_t     cmd;
    logic     out_free;
    logic     emit;
    result_t  res;
    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    // unpack the command beat; payload keeps its low PAYLOAD_BITS
    assign cmd.mode     = s_axis_tuser;
    assign cmd.position = s_axis_tdata[IDX_W-1:0];
    assign cmd.payload  = PAYLOAD_BITS'(s_axis_tdata[IDX_W +: WORD_W]);

    alfp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .out_free (out_free),
        .emit     (emit),
        .res      (res),
        .mem_req  (mem_req),
        .mem_rsp  (mem_rsp)
    );

    alfp_node_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    // output register: free when empty or draining this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_res_next   = m_res_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tlast  = m_res_reg.last;
    assign m_axis_tdata  = OUT_DATA_W'({m_res_reg.pool_full, m_res_reg.list_empty,
                                        m_res_reg.node_next, m_res_reg.node_payload,
                                        m_res_reg.node_index});

endmodule

`default_nettype wire
